FILE: rtl/ndag_pkg.sv
`timescale 1ns / 1ps

package ndag_pkg;

    // Default sizing
    localparam int unsigned DEF_MAX_DIMS    = 4;
    localparam int unsigned DEF_EXTENT_BITS = 12;

    // Fixed port geometry
    localparam int unsigned PORT_DIMS    = 4;
    localparam int unsigned PORT_INDEX_W = 12;
    localparam int unsigned CFG_W        = 13;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned OFF_W        = 48;

    // Request codes
    localparam logic [1:0] REQ_STEP      = 2'd0;
    localparam logic [1:0] REQ_TRANSLATE = 2'd1;
    localparam logic [1:0] REQ_RESTART   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORDER     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_3  = 3'd5;

    // Per-cycle control broadcast to every cell
    typedef struct packed {
        logic order;   // 1: column-major
        logic derive;  // stride derivation pass running
        logic step;    // step request accepted
        logic clear;   // clear the iterator
    } ctl_t;

    // Flags travelling with a request down the chain
    typedef struct packed {
        logic oob;
        logic last;
    } flag_t;

    // Width of a travelling index: wide enough for the iterator and for an echoed query
    function automatic int unsigned idx_width(input int unsigned extent_bits);
        return (extent_bits > PORT_INDEX_W) ? extent_bits : PORT_INDEX_W;
    endfunction

endpackage

FILE: rtl/nd_index_address_generator.sv
`timescale 1ns / 1ps
// An accepted request flows through one cell per dimension (each adds its stride product),
//   then through the output register.
// Throughput: one request per cycle when not stalled; the iterator carry is combinational.
// A config write stalls input in its own cycle; at indexes 0-5 also while strides re-derive.
// Reset (async, active low): row-major, one dimension, extents 1, strides 1, iterator zero,
//   pipeline empty.

module nd_index_address_generator #(
    parameter int unsigned MAX_DIMS    = ndag_pkg::DEF_MAX_DIMS,
    parameter int unsigned EXTENT_BITS = ndag_pkg::DEF_EXTENT_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_we,
    input  logic [ndag_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ndag_pkg::CFG_W-1:0]         cfg_data,
    // request channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         req_type,
    input  logic [ndag_pkg::PORT_INDEX_W-1:0]  query_index_0,
    input  logic [ndag_pkg::PORT_INDEX_W-1:0]  query_index_1,
    input  logic [ndag_pkg::PORT_INDEX_W-1:0]  query_index_2,
    input  logic [ndag_pkg::PORT_INDEX_W-1:0]  query_index_3,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [ndag_pkg::PORT_INDEX_W-1:0]  index_0,
    output logic [ndag_pkg::PORT_INDEX_W-1:0]  index_1,
    output logic [ndag_pkg::PORT_INDEX_W-1:0]  index_2,
    output logic [ndag_pkg::PORT_INDEX_W-1:0]  index_3,
    output logic [ndag_pkg::OFF_W-1:0]         linear_offset,
    output logic                               out_of_bounds,
    output logic                               last_element
);

    localparam int unsigned IDX_W  = ndag_pkg::idx_width(EXTENT_BITS);
    localparam int unsigned EXT_W  = EXTENT_BITS + 1;
    localparam int unsigned OFF_W  = ndag_pkg::OFF_W;
    localparam int unsigned PW     = ndag_pkg::PORT_INDEX_W;
    localparam int unsigned PD     = ndag_pkg::PORT_DIMS;
    localparam int unsigned CNT_W  = $clog2(MAX_DIMS + 1);

    // Configuration and control
    logic                   order_reg;
    logic [2:0]             dim_count_reg;
    logic [CNT_W-1:0]       derive_cnt_reg;
    logic [CNT_W-1:0]       derive_cnt_next;
    logic                   cfg_hit;
    logic                   accept;
    logic                   out_ready;
    ndag_pkg::ctl_t         ctl;
    logic [MAX_DIMS-1:0]    active;

    // Per-cell signals
    logic [OFF_W-1:0]       stride_q   [MAX_DIMS];
    logic [EXT_W-1:0]       ext_q      [MAX_DIMS];
    logic [OFF_W-1:0]       nb_stride  [MAX_DIMS];
    logic [EXT_W-1:0]       nb_ext     [MAX_DIMS];
    logic [MAX_DIMS-1:0]    nb_use;
    logic [MAX_DIMS-1:0]    cin_row;
    logic [MAX_DIMS-1:0]    cin_col;
    logic [MAX_DIMS-1:0]    cout_row;
    logic [MAX_DIMS-1:0]    cout_col;
    logic [MAX_DIMS-1:0]    ext_we;
    logic [IDX_W-1:0]       cell_query [MAX_DIMS];
    logic [IDX_W-1:0]       entry_idx  [MAX_DIMS];
    logic [MAX_DIMS-1:0]    entry_oob;

    // Pipeline: slot 0 is the request being accepted, slot k+1 the output of cell k
    logic [MAX_DIMS:0]                   st_valid;
    logic [MAX_DIMS-1:0][IDX_W-1:0]      st_idx   [MAX_DIMS+1];
    ndag_pkg::flag_t                     st_flags [MAX_DIMS+1];
    logic [OFF_W-1:0]                    st_psum  [MAX_DIMS+1];
    logic [OFF_W-1:0]                    st_prod  [MAX_DIMS+1];
    logic [MAX_DIMS:0]                   rdy;

    // Output register
    logic                                out_valid_reg;
    logic [MAX_DIMS-1:0][IDX_W-1:0]      out_idx_reg;
    logic [OFF_W-1:0]                    out_off_reg;
    logic                                out_oob_reg;
    logic                                out_last_reg;
    logic [PD-1:0][PW-1:0]               port_query;
    logic [PD-1:0][PW-1:0]               port_idx;

    // Handshake and flow control
    assign out_ready = !out_valid_reg || !out_stall;
    assign in_stall  = !rdy[0] || ctl.derive || cfg_we;
    assign accept    = in_valid && !in_stall;
    assign cfg_hit   = cfg_we && (cfg_index <= ndag_pkg::REG_EXTENT_3);

    always_comb
    begin
        rdy[MAX_DIMS] = out_ready;
        for (int k = MAX_DIMS - 1; k >= 0; k--)
            rdy[k] = !st_valid[k+1] || rdy[k+1];
    end

    // Control broadcast
    assign ctl.order  = order_reg;
    assign ctl.derive = (derive_cnt_reg != '0);
    assign ctl.step   = accept && (req_type == ndag_pkg::REQ_STEP);
    assign ctl.clear  = cfg_hit || (accept && (req_type == ndag_pkg::REQ_RESTART));

    // Active dimensions: a count of zero keeps dimension 0
    always_comb
    begin
        for (int d = 0; d < MAX_DIMS; d++)
            active[d] = (d == 0) || (32'(dim_count_reg) > 32'(d));
    end

    // Derivation counter: each write to indexes 0-5 restarts a full pass over the chain
    always_comb
    begin
        derive_cnt_next = derive_cnt_reg;
        if (cfg_hit)
            derive_cnt_next = CNT_W'(MAX_DIMS);
        else if (derive_cnt_reg != '0)
            derive_cnt_next = derive_cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg      <= 1'b0;
            dim_count_reg  <= 3'd1;
            derive_cnt_reg <= '0;
        end
        else
        begin
            derive_cnt_reg <= derive_cnt_next;
            if (cfg_we && (cfg_index == ndag_pkg::REG_ORDER))
                order_reg <= cfg_data[0];
            if (cfg_we && (cfg_index == ndag_pkg::REG_DIM_COUNT))
                dim_count_reg <= cfg_data[2:0];
        end
    end

    // Query ports as an array
    assign port_query[0] = query_index_0;
    assign port_query[1] = query_index_1;
    assign port_query[2] = query_index_2;
    assign port_query[3] = query_index_3;

    // Cell wiring
    for (genvar k = 0; k < MAX_DIMS; k++)
    begin : g_wire
        if (k < PD)
        begin : g_port
            assign cell_query[k] = IDX_W'(port_query[k]);
            assign ext_we[k]     = cfg_we &&
                                   (cfg_index == ndag_pkg::CFG_IDX_W'(ndag_pkg::REG_EXTENT_0 + k));
        end
        else
        begin : g_noport
            assign cell_query[k] = '0;
            assign ext_we[k]     = 1'b0;
        end

        // row-major carry enters at the top cell, column-major at cell 0
        if (k == MAX_DIMS - 1)
        begin : g_row_top
            assign cin_row[k] = 1'b1;
        end
        else
        begin : g_row_mid
            assign cin_row[k] = cout_row[k+1];
        end
        if (k == 0)
        begin : g_col_bot
            assign cin_col[k] = 1'b1;
        end
        else
        begin : g_col_mid
            assign cin_col[k] = cout_col[k-1];
        end

        // stride neighbour: the next faster dimension
        if (MAX_DIMS == 1)
        begin : g_nb_single
            assign nb_stride[k] = OFF_W'(1);
            assign nb_ext[k]    = EXT_W'(1);
            assign nb_use[k]    = 1'b0;
        end
        else if (k == 0)
        begin : g_nb_bot
            assign nb_stride[k] = order_reg ? OFF_W'(1) : stride_q[k+1];
            assign nb_ext[k]    = order_reg ? EXT_W'(1) : ext_q[k+1];
            assign nb_use[k]    = order_reg ? 1'b0 : active[k+1];
        end
        else if (k == MAX_DIMS - 1)
        begin : g_nb_top
            assign nb_stride[k] = order_reg ? stride_q[k-1] : OFF_W'(1);
            assign nb_ext[k]    = order_reg ? ext_q[k-1] : EXT_W'(1);
            assign nb_use[k]    = order_reg ? active[k] : 1'b0;
        end
        else
        begin : g_nb_mid
            assign nb_stride[k] = order_reg ? stride_q[k-1] : stride_q[k+1];
            assign nb_ext[k]    = order_reg ? ext_q[k-1] : ext_q[k+1];
            assign nb_use[k]    = order_reg ? active[k] : active[k+1];
        end
    end

    // Head of the pipeline: the request being accepted
    always_comb
    begin
        st_valid[0]      = accept;
        st_flags[0].oob  = |entry_oob;
        st_flags[0].last = (req_type == ndag_pkg::REQ_STEP) &&
                           (order_reg ? cout_col[MAX_DIMS-1] : cout_row[0]);
        st_psum[0]       = '0;
        st_prod[0]       = '0;
        for (int k = 0; k < MAX_DIMS; k++)
            st_idx[0][k] = entry_idx[k];
    end

    // Row of cells
    for (genvar k = 0; k < MAX_DIMS; k++)
    begin : g_cell
        ndag_cell #(
            .MAX_DIMS    (MAX_DIMS),
            .EXTENT_BITS (EXTENT_BITS),
            .CELL_ID     (k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .active     (active[k]),
            .req_type   (req_type),
            .query      (cell_query[k]),
            .ext_we     (ext_we[k]),
            .ext_wdata  (cfg_data),
            .nb_use     (nb_use[k]),
            .nb_stride  (nb_stride[k]),
            .nb_ext     (nb_ext[k]),
            .stride_out (stride_q[k]),
            .ext_out    (ext_q[k]),
            .cin_row    (cin_row[k]),
            .cin_col    (cin_col[k]),
            .cout_row   (cout_row[k]),
            .cout_col   (cout_col[k]),
            .entry_idx  (entry_idx[k]),
            .entry_oob  (entry_oob[k]),
            .load       (rdy[k]),
            .up_valid   (st_valid[k]),
            .up_idx     (st_idx[k]),
            .up_flags   (st_flags[k]),
            .up_psum    (st_psum[k]),
            .up_prod    (st_prod[k]),
            .dn_valid   (st_valid[k+1]),
            .dn_idx     (st_idx[k+1]),
            .dn_flags   (st_flags[k+1]),
            .dn_psum    (st_psum[k+1]),
            .dn_prod    (st_prod[k+1])
        );
    end

    // Output register: final add, zero offset when out of bounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= st_valid[MAX_DIMS];
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && st_valid[MAX_DIMS])
        begin
            out_idx_reg  <= st_idx[MAX_DIMS];
            out_oob_reg  <= st_flags[MAX_DIMS].oob;
            out_last_reg <= st_flags[MAX_DIMS].last;
            out_off_reg  <= st_flags[MAX_DIMS].oob ? '0
                                                   : st_psum[MAX_DIMS] + st_prod[MAX_DIMS];
        end
    end

    // Result ports
    for (genvar k = 0; k < PD; k++)
    begin : g_out
        if (k < MAX_DIMS)
        begin : g_used
            assign port_idx[k] = out_idx_reg[k][PW-1:0];
        end
        else
        begin : g_unused
            assign port_idx[k] = '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign index_0       = port_idx[0];
    assign index_1       = port_idx[1];
    assign index_2       = port_idx[2];
    assign index_3       = port_idx[3];
    assign linear_offset = out_off_reg;
    assign out_of_bounds = out_oob_reg;
    assign last_element  = out_last_reg;

    // Checks
    a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_bounds |-> linear_offset == '0)
        else $error("out-of-bounds result with non-zero offset");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_of_bounds && last_element))
        else $error("result flagged both out of bounds and last element");

    a_cfg_derive: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> ctl.derive && in_stall)
        else $error("register write did not start stride derivation");

    a_accept_enter: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> st_valid[1])
        else $error("accepted request did not enter the first cell");

endmodule

FILE: rtl/ndag_cell.sv
`timescale 1ns / 1ps

module ndag_cell #(
    parameter int unsigned MAX_DIMS    = ndag_pkg::DEF_MAX_DIMS,
    parameter int unsigned EXTENT_BITS = ndag_pkg::DEF_EXTENT_BITS,
    parameter int unsigned CELL_ID     = 0
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ndag_pkg::ctl_t                         ctl,
    input  logic                                   active,
    input  logic [1:0]                             req_type,
    input  logic [ndag_pkg::idx_width(EXTENT_BITS)-1:0] query,
    input  logic                                   ext_we,
    input  logic [ndag_pkg::CFG_W-1:0]             ext_wdata,
    // neighbour for stride derivation
    input  logic                                   nb_use,
    input  logic [ndag_pkg::OFF_W-1:0]             nb_stride,
    input  logic [EXTENT_BITS:0]                   nb_ext,
    output logic [ndag_pkg::OFF_W-1:0]             stride_out,
    output logic [EXTENT_BITS:0]                   ext_out,
    // carry chains, one per storage order
    input  logic                                   cin_row,
    input  logic                                   cin_col,
    output logic                                   cout_row,
    output logic                                   cout_col,
    // index this cell contributes to a new request
    output logic [ndag_pkg::idx_width(EXTENT_BITS)-1:0] entry_idx,
    output logic                                   entry_oob,
    // offset pipeline
    input  logic                                   load,
    input  logic                                   up_valid,
    input  logic [MAX_DIMS-1:0][ndag_pkg::idx_width(EXTENT_BITS)-1:0] up_idx,
    input  ndag_pkg::flag_t                        up_flags,
    input  logic [ndag_pkg::OFF_W-1:0]             up_psum,
    input  logic [ndag_pkg::OFF_W-1:0]             up_prod,
    output logic                                   dn_valid,
    output logic [MAX_DIMS-1:0][ndag_pkg::idx_width(EXTENT_BITS)-1:0] dn_idx,
    output ndag_pkg::flag_t                        dn_flags,
    output logic [ndag_pkg::OFF_W-1:0]             dn_psum,
    output logic [ndag_pkg::OFF_W-1:0]             dn_prod
);

    localparam int unsigned IDX_W   = ndag_pkg::idx_width(EXTENT_BITS);
    localparam int unsigned EXT_W   = EXTENT_BITS + 1;
    localparam int unsigned MB_W    = IDX_W + 1;
    localparam int unsigned OFF_W   = ndag_pkg::OFF_W;
    localparam logic [31:0] EXT_MAX = 32'(1) << EXTENT_BITS;

    logic [EXTENT_BITS-1:0] it_reg;
    logic [EXTENT_BITS-1:0] it_next;
    logic [EXT_W-1:0]       ext_reg;
    logic [EXT_W-1:0]       ext_clamp;
    logic [OFF_W-1:0]       stride_reg;
    logic [OFF_W-1:0]       stride_next;
    logic [EXT_W-1:0]       it_inc;
    logic                   wrap;
    logic                   cin_eff;
    logic [OFF_W-1:0]       mul_a;
    logic [MB_W-1:0]        mul_b;
    logic [OFF_W-1:0]       mul_res;

    logic                   valid_reg;
    logic [MAX_DIMS-1:0][IDX_W-1:0] idx_reg;
    ndag_pkg::flag_t        flags_reg;
    logic [OFF_W-1:0]       psum_reg;
    logic [OFF_W-1:0]       prod_reg;

    // Extent clamp: zero counts as one, too large saturates
    always_comb
    begin
        if (ext_wdata == '0)
            ext_clamp = EXT_W'(1);
        else if (32'(ext_wdata) > EXT_MAX)
            ext_clamp = EXT_W'(EXT_MAX);
        else
            ext_clamp = EXT_W'(ext_wdata);
    end

    // Increment and carry, in both chain directions
    assign it_inc   = {1'b0, it_reg} + EXT_W'(1);
    assign wrap     = (it_inc >= ext_reg);
    assign cout_row = active ? (cin_row && wrap) : cin_row;
    assign cout_col = active ? (cin_col && wrap) : cin_col;
    assign cin_eff  = ctl.order ? cin_col : cin_row;

    always_comb
    begin
        it_next = it_reg;
        if (ctl.clear)
            it_next = '0;
        else if (ctl.step && active && cin_eff)
            it_next = wrap ? '0 : it_inc[EXTENT_BITS-1:0];
    end

    // Index offered for a new request
    always_comb
    begin
        entry_idx = '0;
        entry_oob = 1'b0;
        case (req_type)
            ndag_pkg::REQ_STEP:
            begin
                if (active)
                    entry_idx = IDX_W'(it_reg);
            end
            ndag_pkg::REQ_TRANSLATE:
            begin
                if (active)
                begin
                    entry_idx = query;
                    entry_oob = (MB_W'(query) >= MB_W'(ext_reg));
                end
            end
            default:
            begin
                entry_idx = '0;
            end
        endcase
    end

    // Shared multiplier: stride derivation or stride times index
    assign mul_a   = ctl.derive ? nb_stride : stride_reg;
    assign mul_b   = ctl.derive ? MB_W'(nb_ext) : MB_W'(up_idx[CELL_ID]);
    assign mul_res = mul_a * OFF_W'(mul_b);

    assign stride_next = nb_use ? mul_res : OFF_W'(1);

    // Cell state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            it_reg     <= '0;
            ext_reg    <= EXT_W'(1);
            stride_reg <= OFF_W'(1);
            valid_reg  <= 1'b0;
        end
        else
        begin
            it_reg <= it_next;
            if (ext_we)
                ext_reg <= ext_clamp;
            if (ctl.derive)
                stride_reg <= stride_next;
            if (load)
                valid_reg <= up_valid;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (load && up_valid)
        begin
            idx_reg   <= up_idx;
            flags_reg <= up_flags;
            prod_reg  <= mul_res;
            psum_reg  <= up_psum + up_prod;
        end
    end

    assign stride_out = stride_reg;
    assign ext_out    = ext_reg;
    assign dn_valid   = valid_reg;
    assign dn_idx     = idx_reg;
    assign dn_flags   = flags_reg;
    assign dn_psum    = psum_reg;
    assign dn_prod    = prod_reg;

endmodule
